// ----- rtl/nrmc_pkg.sv -----
// Package with the shared types and constants of the RMC position parser.
`timescale 1ns / 1ps

package nrmc_pkg;

  typedef enum logic [3:0] {
    PhHuntC   = 4'd0,
    PhHuntA   = 4'd1,
    PhSkipLat = 4'd2,
    PhLatDeg  = 4'd3,
    PhLatMin  = 4'd4,
    PhHuntN   = 4'd5,
    PhSkipLon = 4'd6,
    PhLonDeg  = 4'd7,
    PhLonMin  = 4'd8,
    PhHuntW   = 4'd9,
    PhSkipSpd = 4'd10,
    PhSpeed   = 4'd11
  } phase_e;

  typedef struct packed {
    logic [6:0]  lat_deg;
    logic [19:0] lat_min;
    logic [9:0]  lon_deg;
    logic [19:0] lon_min;
    logic [7:0]  speed;
  } fix_raw_t;

  localparam logic [7:0] CharC     = 8'h43;
  localparam logic [7:0] CharA     = 8'h41;
  localparam logic [7:0] CharN     = 8'h4E;
  localparam logic [7:0] CharW     = 8'h57;
  localparam logic [7:0] CharPoint = 8'h2E;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;

  localparam logic [2:0] LatDegLast  = 3'd1;
  localparam logic [2:0] LonDegLast  = 3'd2;
  localparam logic [2:0] MinLast     = 3'd6;
  localparam logic [2:0] MinPointPos = 3'd2;
  localparam logic [2:0] SpeedLast   = 3'd3;

  localparam logic [7:0]  SpeedMax   = 8'd255;
  localparam logic [19:0] UdegPerDeg = 20'd1000000;

  // floor(x / 3) = (x * Div3Mul) >> Div3Shift for every x below 2**25.
  localparam logic [23:0] Div3Mul   = 24'd11184811;
  localparam int          Div3Shift = 25;

  localparam int QueueDepth = 2;

endpackage

// ----- rtl/nrmc_if.sv -----
// Valid/ready channel interfaces for received bytes and parsed fixes.
`timescale 1ns / 1ps

interface nrmc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface nrmc_fix_if;
  logic               valid;
  logic               ready;
  logic [26:0]        latitude_udeg;
  logic signed [30:0] longitude_udeg;
  logic [7:0]         speed_knots;

  modport source (output valid, output latitude_udeg, output longitude_udeg,
                  output speed_knots, input ready);
  modport sink (input valid, input latitude_udeg, input longitude_udeg,
                input speed_knots, output ready);
endinterface

// ----- rtl/nrmc_front.sv -----
// Byte-level sentence parser that collects the raw position and speed fields.
`timescale 1ns / 1ps

module nrmc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  nrmc_byte_if.sink         in_i,
  input  logic              full_i,
  output logic              push_o,
  output nrmc_pkg::fix_raw_t push_data_o
);

  nrmc_pkg::phase_e phase_q, phase_d;
  logic [2:0]  idx_q, idx_d, idx_inc;
  logic        stop_q, stop_d;
  logic [6:0]  lat_deg_q, lat_deg_d;
  logic [19:0] lat_min_q, lat_min_d;
  logic [9:0]  lon_deg_q, lon_deg_d;
  logic [19:0] lon_min_q, lon_min_d;
  logic [7:0]  speed_q, speed_d;

  logic        accept;
  logic        is_dig;
  logic [3:0]  dig;
  logic [9:0]  deg_cur;
  logic [11:0] deg_calc;
  logic        deg_stop;
  logic [7:0]  deg_sat;
  logic [19:0] min_cur;
  logic [19:0] min_calc;
  logic        min_stop;
  logic [9:0]  frac_w;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign is_dig     = (in_i.rx_byte >= nrmc_pkg::CharZero) &&
                      (in_i.rx_byte <= nrmc_pkg::CharNine);
  assign dig        = in_i.rx_byte[3:0];
  assign idx_inc    = idx_q + 3'd1;

  always_comb begin
    case (phase_q)
      nrmc_pkg::PhLatDeg: deg_cur = {3'b000, lat_deg_q};
      nrmc_pkg::PhLonDeg: deg_cur = lon_deg_q;
      default:            deg_cur = {2'b00, speed_q};
    endcase
    deg_stop = stop_q || !is_dig;
    if (deg_stop) begin
      deg_calc = {2'b00, deg_cur};
    end else begin
      deg_calc = 12'({2'b00, deg_cur} * 12'd10 + {8'd0, dig});
    end
    deg_sat = (deg_calc > {4'd0, nrmc_pkg::SpeedMax}) ? nrmc_pkg::SpeedMax : deg_calc[7:0];
  end

  always_comb begin
    case (idx_q)
      3'd3:    frac_w = 10'd1000;
      3'd4:    frac_w = 10'd100;
      3'd5:    frac_w = 10'd10;
      3'd6:    frac_w = 10'd1;
      default: frac_w = 10'd0;
    endcase
    min_cur  = (phase_q == nrmc_pkg::PhLonMin) ? lon_min_q : lat_min_q;
    min_calc = min_cur;
    min_stop = stop_q;
    if (!stop_q) begin
      if (idx_q == nrmc_pkg::MinPointPos) begin
        min_stop = (in_i.rx_byte != nrmc_pkg::CharPoint);
      end else if (!is_dig || idx_q > nrmc_pkg::MinLast) begin
        min_stop = 1'b1;
      end else if (idx_q < nrmc_pkg::MinPointPos) begin
        min_calc = 20'(min_cur * 20'd10 + {16'd0, dig} * 20'd10000);
      end else begin
        min_calc = 20'(min_cur + {16'd0, dig} * {10'd0, frac_w});
      end
    end
  end

  always_comb begin
    phase_d   = phase_q;
    idx_d     = idx_q;
    stop_d    = stop_q;
    lat_deg_d = lat_deg_q;
    lat_min_d = lat_min_q;
    lon_deg_d = lon_deg_q;
    lon_min_d = lon_min_q;
    speed_d   = speed_q;
    push_o    = 1'b0;
    if (accept) begin
      case (phase_q)
        nrmc_pkg::PhHuntC: begin
          if (in_i.rx_byte == nrmc_pkg::CharC) phase_d = nrmc_pkg::PhHuntA;
        end
        nrmc_pkg::PhHuntA: begin
          if (in_i.rx_byte == nrmc_pkg::CharA) phase_d = nrmc_pkg::PhSkipLat;
        end
        nrmc_pkg::PhSkipLat: begin
          lat_deg_d = '0;
          phase_d   = nrmc_pkg::PhLatDeg;
          idx_d     = '0;
          stop_d    = 1'b0;
        end
        nrmc_pkg::PhLatDeg: begin
          lat_deg_d = deg_calc[6:0];
          stop_d    = deg_stop;
          idx_d     = idx_inc;
          if (idx_q == nrmc_pkg::LatDegLast) begin
            lat_min_d = '0;
            phase_d   = nrmc_pkg::PhLatMin;
            idx_d     = '0;
            stop_d    = 1'b0;
          end
        end
        nrmc_pkg::PhLatMin: begin
          lat_min_d = min_calc;
          stop_d    = min_stop;
          idx_d     = idx_inc;
          if (idx_q == nrmc_pkg::MinLast) begin
            phase_d = nrmc_pkg::PhHuntN;
            idx_d   = '0;
            stop_d  = 1'b0;
          end
        end
        nrmc_pkg::PhHuntN: begin
          if (in_i.rx_byte == nrmc_pkg::CharN) phase_d = nrmc_pkg::PhSkipLon;
        end
        nrmc_pkg::PhSkipLon: begin
          lon_deg_d = '0;
          phase_d   = nrmc_pkg::PhLonDeg;
          idx_d     = '0;
          stop_d    = 1'b0;
        end
        nrmc_pkg::PhLonDeg: begin
          lon_deg_d = deg_calc[9:0];
          stop_d    = deg_stop;
          idx_d     = idx_inc;
          if (idx_q == nrmc_pkg::LonDegLast) begin
            lon_min_d = '0;
            phase_d   = nrmc_pkg::PhLonMin;
            idx_d     = '0;
            stop_d    = 1'b0;
          end
        end
        nrmc_pkg::PhLonMin: begin
          lon_min_d = min_calc;
          stop_d    = min_stop;
          idx_d     = idx_inc;
          if (idx_q == nrmc_pkg::MinLast) begin
            phase_d = nrmc_pkg::PhHuntW;
            idx_d   = '0;
            stop_d  = 1'b0;
          end
        end
        nrmc_pkg::PhHuntW: begin
          if (in_i.rx_byte == nrmc_pkg::CharW) phase_d = nrmc_pkg::PhSkipSpd;
        end
        nrmc_pkg::PhSkipSpd: begin
          speed_d = '0;
          phase_d = nrmc_pkg::PhSpeed;
          idx_d   = '0;
          stop_d  = 1'b0;
        end
        nrmc_pkg::PhSpeed: begin
          speed_d = deg_sat;
          stop_d  = deg_stop;
          idx_d   = idx_inc;
          if (idx_q == nrmc_pkg::SpeedLast) begin
            push_o  = 1'b1;
            phase_d = nrmc_pkg::PhHuntC;
            idx_d   = '0;
            stop_d  = 1'b0;
          end
        end
        default: begin
          phase_d = nrmc_pkg::PhHuntC;
          idx_d   = '0;
          stop_d  = 1'b0;
        end
      endcase
    end
  end

  assign push_data_o.lat_deg = lat_deg_q;
  assign push_data_o.lat_min = lat_min_q;
  assign push_data_o.lon_deg = lon_deg_q;
  assign push_data_o.lon_min = lon_min_q;
  assign push_data_o.speed   = deg_sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= nrmc_pkg::PhHuntC;
      idx_q     <= '0;
      stop_q    <= 1'b0;
      lat_deg_q <= '0;
      lat_min_q <= '0;
      lon_deg_q <= '0;
      lon_min_q <= '0;
      speed_q   <= '0;
    end else begin
      phase_q   <= phase_d;
      idx_q     <= idx_d;
      stop_q    <= stop_d;
      lat_deg_q <= lat_deg_d;
      lat_min_q <= lat_min_d;
      lon_deg_q <= lon_deg_d;
      lon_min_q <= lon_min_d;
      speed_q   <= speed_d;
    end
  end

  // The position counter only runs inside a numeric field.
  a_idx_zero_outside_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == nrmc_pkg::PhHuntC || phase_q == nrmc_pkg::PhHuntA ||
     phase_q == nrmc_pkg::PhHuntN || phase_q == nrmc_pkg::PhHuntW ||
     phase_q == nrmc_pkg::PhSkipLat || phase_q == nrmc_pkg::PhSkipLon ||
     phase_q == nrmc_pkg::PhSkipSpd) |-> idx_q == 3'd0)
    else $error("field position counter is not zero outside a field");

  // A fix is pushed only on the last speed character and never into a full queue.
  a_push_on_last_speed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (phase_q == nrmc_pkg::PhSpeed && idx_q == nrmc_pkg::SpeedLast && !full_i))
    else $error("fix pushed outside the last speed character or into a full queue");

  a_return_to_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> phase_q == nrmc_pkg::PhHuntC)
    else $error("parser did not return to hunting after a fix");

endmodule

// ----- rtl/nrmc_queue.sv -----
// Short queue of raw fixes between the parser and the conversion pipeline.
`timescale 1ns / 1ps

module nrmc_queue #(
  parameter int Depth = nrmc_pkg::QueueDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  nrmc_pkg::fix_raw_t push_data_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               avail_o,
  output nrmc_pkg::fix_raw_t pop_data_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  nrmc_pkg::fix_raw_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign avail_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && avail_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  a_cnt_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue fill count exceeds its depth");

endmodule

// ----- rtl/nrmc_back.sv -----
// Conversion pipeline from raw fields to microdegrees, with the output register.
`timescale 1ns / 1ps

module nrmc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               avail_i,
  input  nrmc_pkg::fix_raw_t fix_i,
  output logic               pop_o,
  nrmc_fix_if.source         out_o
);

  logic        adv;
  logic        s1_v_q, s2_v_q, out_v_q;

  logic [26:0] s1_lat_deg_q;
  logic [22:0] s1_lat_min5_q;
  logic [29:0] s1_lon_deg_q;
  logic [22:0] s1_lon_min5_q;
  logic [7:0]  s1_speed_q;

  logic [46:0] lat_prod, lon_prod;
  logic [26:0] s2_lat_deg_q;
  logic [20:0] s2_lat_frac_q;
  logic [29:0] s2_lon_deg_q;
  logic [20:0] s2_lon_frac_q;
  logic [7:0]  s2_speed_q;

  logic [26:0] lat_sum;
  logic [29:0] lon_sum;
  logic [26:0] out_lat_q;
  logic [30:0] out_lon_q;
  logic [7:0]  out_speed_q;

  assign adv   = !out_v_q || out_o.ready;
  assign pop_o = adv && avail_i;

  assign lat_prod = s1_lat_min5_q * nrmc_pkg::Div3Mul;
  assign lon_prod = s1_lon_min5_q * nrmc_pkg::Div3Mul;
  assign lat_sum  = s2_lat_deg_q + {6'd0, s2_lat_frac_q};
  assign lon_sum  = s2_lon_deg_q + {9'd0, s2_lon_frac_q};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_lat_deg_q  <= 27'(fix_i.lat_deg * nrmc_pkg::UdegPerDeg);
      s1_lat_min5_q <= 23'({fix_i.lat_min, 2'b00} + {3'b000, fix_i.lat_min});
      s1_lon_deg_q  <= 30'(fix_i.lon_deg * nrmc_pkg::UdegPerDeg);
      s1_lon_min5_q <= 23'({fix_i.lon_min, 2'b00} + {3'b000, fix_i.lon_min});
      s1_speed_q    <= fix_i.speed;
      s2_lat_deg_q  <= s1_lat_deg_q;
      s2_lat_frac_q <= lat_prod[nrmc_pkg::Div3Shift +: 21];
      s2_lon_deg_q  <= s1_lon_deg_q;
      s2_lon_frac_q <= lon_prod[nrmc_pkg::Div3Shift +: 21];
      s2_speed_q    <= s1_speed_q;
      out_lat_q     <= lat_sum;
      out_lon_q     <= 31'd0 - {1'b0, lon_sum};
      out_speed_q   <= s2_speed_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q  <= avail_i;
      s2_v_q  <= s1_v_q;
      out_v_q <= s2_v_q;
    end
  end

  assign out_o.valid          = out_v_q;
  assign out_o.latitude_udeg  = out_lat_q;
  assign out_o.longitude_udeg = $signed(out_lon_q);
  assign out_o.speed_knots    = out_speed_q;

  a_pop_only_on_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> s1_v_q)
    else $error("popped fix did not enter the pipeline");

  a_out_from_stage2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_v_q) |-> $past(s2_v_q))
    else $error("output became valid without a fix in the last stage");

endmodule

// ----- rtl/nmea_rmc_position_parser_top.sv -----
// Top level of the RMC position parser: parser, fix queue and conversion pipeline.
`timescale 1ns / 1ps
//
//  Port    | Dir | Payload                                        | Item
//  in_i    | in  | rx_byte[7:0]                                   | one received character
//  out_o   | out | latitude_udeg, longitude_udeg, speed_knots     | one parsed fix
//
//  One character is taken each cycle; the parser updates its field state in one step.
//  A fix reaches the output register through the fix queue and pipeline stages s1 and s2.
//  The conversion pipeline holds three fixes and the queue QueueDepth more.
//  Input ready drops only while the fix queue is full; a stalled output freezes the pipeline.
//  Reset is asynchronous and returns the parser to hunting for the letter C.

module nmea_rmc_position_parser_top #(
  parameter int QueueDepth = nrmc_pkg::QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  nrmc_byte_if.sink  in_i,
  nrmc_fix_if.source out_o
);

  logic               push, full, pop, avail;
  nrmc_pkg::fix_raw_t push_data, pop_data;

  nrmc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  nrmc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .avail_o     (avail),
    .pop_data_o  (pop_data)
  );

  nrmc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .avail_i (avail),
    .fix_i   (pop_data),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

// ----- tb/nrmc_fix_checker.sv -----
// Checker that predicts parsed fixes from accepted bytes and compares them with the output.
`timescale 1ns / 1ps

module nrmc_fix_checker (
  input  logic  clk_i,
  input  logic  rst_ni,
  nrmc_byte_if  byte_i,
  nrmc_fix_if   fix_i,
  output int    mismatches_o,
  output int    fixes_pending_o
);
  import nrmc_pkg::*;

  typedef struct {
    logic [26:0]        lat;
    logic signed [30:0] lon;
    logic [7:0]         speed;
  } fix_t;

  fix_t expected_fixes[$];
  int   mismatch_count = 0;

  phase_e      phase;
  logic [2:0]  field_pos;
  logic        number_done;
  logic [6:0]  lat_deg;
  logic [19:0] lat_min_e4;
  logic [9:0]  lon_deg;
  logic [19:0] lon_min_e4;
  logic [7:0]  knots;

  assign mismatches_o = mismatch_count;

  function automatic bit is_digit(logic [7:0] c);
    return c >= CharZero && c <= CharNine;
  endfunction

  function automatic void start_field(phase_e next_phase);
    phase = next_phase;
    field_pos = '0;
    number_done = 1'b0;
  endfunction

  function automatic void clear_parser();
    start_field(PhHuntC);
    lat_deg = '0;
    lat_min_e4 = '0;
    lon_deg = '0;
    lon_min_e4 = '0;
    knots = '0;
  endfunction

  function automatic int unsigned add_whole_digit(int unsigned acc, logic [7:0] c);
    if (number_done) return acc;
    if (!is_digit(c)) begin
      number_done = 1'b1;
      return acc;
    end
    return acc * 10 + (c - CharZero);
  endfunction

  function automatic int unsigned add_minute_char(int unsigned acc, logic [2:0] pos,
                                                  logic [7:0] c);
    int unsigned d;
    if (number_done) return acc;
    if (pos == MinPointPos) begin
      if (c != CharPoint) number_done = 1'b1;
      return acc;
    end
    if (!is_digit(c) || pos > MinLast) begin
      number_done = 1'b1;
      return acc;
    end
    d = c - CharZero;
    case (pos)
      3'd0, 3'd1: return acc * 10 + d * 10000;
      3'd3: return acc + d * 1000;
      3'd4: return acc + d * 100;
      3'd5: return acc + d * 10;
      default: return acc + d;
    endcase
  endfunction

  function automatic longint to_microdeg(longint deg, longint min_e4);
    return deg * 1000000 + (min_e4 * 100) / 60;
  endfunction

  function automatic void predict_byte(logic [7:0] c);
    int unsigned v;
    longint      lat_u;
    longint      lon_u;
    fix_t        f;
    case (phase)
      PhHuntC: if (c == CharC) phase = PhHuntA;
      PhHuntA: if (c == CharA) phase = PhSkipLat;
      PhSkipLat: begin
        lat_deg = '0;
        start_field(PhLatDeg);
      end
      PhLatDeg: begin
        lat_deg = 7'(add_whole_digit(lat_deg, c));
        if (field_pos == LatDegLast) begin
          lat_min_e4 = '0;
          start_field(PhLatMin);
        end else begin
          field_pos++;
        end
      end
      PhLatMin: begin
        lat_min_e4 = 20'(add_minute_char(lat_min_e4, field_pos, c));
        if (field_pos == MinLast) start_field(PhHuntN);
        else field_pos++;
      end
      PhHuntN: if (c == CharN) phase = PhSkipLon;
      PhSkipLon: begin
        lon_deg = '0;
        start_field(PhLonDeg);
      end
      PhLonDeg: begin
        lon_deg = 10'(add_whole_digit(lon_deg, c));
        if (field_pos == LonDegLast) begin
          lon_min_e4 = '0;
          start_field(PhLonMin);
        end else begin
          field_pos++;
        end
      end
      PhLonMin: begin
        lon_min_e4 = 20'(add_minute_char(lon_min_e4, field_pos, c));
        if (field_pos == MinLast) start_field(PhHuntW);
        else field_pos++;
      end
      PhHuntW: if (c == CharW) phase = PhSkipSpd;
      PhSkipSpd: begin
        knots = '0;
        start_field(PhSpeed);
      end
      PhSpeed: begin
        v = add_whole_digit(knots, c);
        knots = (v > SpeedMax) ? SpeedMax : 8'(v);
        if (field_pos == SpeedLast) begin
          lat_u = to_microdeg(lat_deg, lat_min_e4);
          lon_u = -to_microdeg(lon_deg, lon_min_e4);
          f.lat = lat_u[26:0];
          f.lon = lon_u[30:0];
          f.speed = knots;
          expected_fixes.push_back(f);
          start_field(PhHuntC);
        end else begin
          field_pos++;
        end
      end
      default: start_field(PhHuntC);
    endcase
  endfunction

  function automatic void compare_field(string field_name, longint want, longint got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field_name, want, got);
      mismatch_count++;
    end
  endfunction

  initial clear_parser();

  always @(posedge clk_i) begin : watch_channels
    fix_t want;
    if (!rst_ni) begin
      clear_parser();
      expected_fixes.delete();
    end else begin
      if (byte_i.valid && byte_i.ready) predict_byte(byte_i.rx_byte);
      if (fix_i.valid && fix_i.ready) begin
        if (expected_fixes.size() == 0) begin
          $display("%0t: unexpected fix: expected none, actual lat %0d, lon %0d, speed %0d",
                   $time, fix_i.latitude_udeg, fix_i.longitude_udeg, fix_i.speed_knots);
          mismatch_count++;
        end else begin
          want = expected_fixes.pop_front();
          compare_field("latitude_udeg", want.lat, fix_i.latitude_udeg);
          compare_field("longitude_udeg", want.lon, fix_i.longitude_udeg);
          compare_field("speed_knots", want.speed, fix_i.speed_knots);
        end
      end
    end
    fixes_pending_o <= expected_fixes.size();
  end

endmodule

// ----- tb/tb_nmea_rmc_position_parser_top.sv -----
// Testbench top of the RMC position parser: byte stimulus, output stalls and verdict.
`timescale 1ns / 1ps

module tb_nmea_rmc_position_parser_top;
  import nrmc_pkg::*;

  localparam int ByteTarget    = 1400;
  localparam int FixTarget     = 20;
  localparam int MidDrainAt    = 20;
  localparam int HoldOffAfter  = 6;
  localparam int HoldOffCycles = 2000;
  localparam int TailCycles    = 16;
  localparam int CycleLimit    = 200000;

  logic clk_i;
  logic rst_ni;

  nrmc_byte_if byte_ch ();
  nrmc_fix_if  fix_ch ();

  int         mismatches;
  int         fixes_pending;
  int         cycle_count;
  int         bytes_sent;
  int         fixes_planned;
  int         random_sentences;
  bit         send_burst;
  bit         mid_drained;
  logic [7:0] sentence_q[$];

  nmea_rmc_position_parser_top uut (
    .clk_i,
    .rst_ni,
    .in_i (byte_ch),
    .out_o(fix_ch)
  );

  nrmc_fix_checker u_fix_checker (
    .clk_i,
    .rst_ni,
    .byte_i         (byte_ch),
    .fix_i          (fix_ch),
    .mismatches_o   (mismatches),
    .fixes_pending_o(fixes_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int pick_gap(bit burst);
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  task automatic push_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap(send_burst);
    if (gap > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    byte_ch.valid <= 1'b1;
    byte_ch.rx_byte <= b;
    @(posedge clk_i);
    while (!byte_ch.ready) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_sentence();
    foreach (sentence_q[i]) push_byte(sentence_q[i]);
    sentence_q.delete();
  endtask

  task automatic wait_for_fixes();
    byte_ch.valid <= 1'b0;
    do @(posedge clk_i); while (fixes_pending != 0);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) sentence_q.push_back(s[i]);
  endtask

  task automatic add_line_end();
    sentence_q.push_back(8'h0D);
    sentence_q.push_back(8'h0A);
  endtask

  function automatic logic [7:0] rand_digit_char();
    if ($urandom_range(0, 15) == 0) return 8'($urandom_range(0, 255));
    return 8'(CharZero + $urandom_range(0, 9));
  endfunction

  task automatic add_number(input int len, input int point_pos);
    for (int i = 0; i < len; i++) begin
      if (i == point_pos && $urandom_range(0, 9) != 0) sentence_q.push_back(CharPoint);
      else sentence_q.push_back(rand_digit_char());
    end
  endtask

  task automatic build_random_sentence();
    string hex_digits;
    int    kind;
    int    cut;
    hex_digits = "0123456789ABCDEF";
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      repeat ($urandom_range(1, 40)) sentence_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    repeat ($urandom_range(0, 3)) sentence_q.push_back(8'($urandom_range(128, 255)));
    add_text("$GPRMC,");
    add_number($urandom_range(0, 6), -1);
    add_text(",A,");
    add_number(2, -1);
    add_number(7, 2);
    add_text(",N,");
    add_number(3, -1);
    add_number(7, 2);
    add_text(",W,");
    add_number(4, $urandom_range(0, 6));
    add_text(",*");
    sentence_q.push_back(hex_digits[$urandom_range(0, 15)]);
    sentence_q.push_back(hex_digits[$urandom_range(0, 15)]);
    add_line_end();
    if (kind == 1) begin
      cut = $urandom_range(1, sentence_q.size() - 1);
      while (sentence_q.size() > cut) void'(sentence_q.pop_back());
    end else begin
      fixes_planned++;
    end
  endtask

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : fix_drain
    int stall_left;
    int fixes_taken;
    bit held;
    bit recv_burst;
    stall_left = 0;
    fixes_taken = 0;
    held = 1'b0;
    recv_burst = 1'b0;
    fix_ch.ready <= 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      @(posedge clk_i);
      if (fix_ch.valid && fix_ch.ready) fixes_taken++;
      if ($urandom_range(0, 63) == 0) recv_burst = !recv_burst;
      if (!held && fixes_taken >= HoldOffAfter) begin
        held = 1'b1;
        stall_left = HoldOffCycles;
      end else if (stall_left == 0 && fix_ch.ready) begin
        stall_left = pick_gap(recv_burst);
      end
      if (stall_left > 0) begin
        fix_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        fix_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    bytes_sent = 0;
    fixes_planned = 0;
    random_sentences = 0;
    send_burst = 1'b0;
    mid_drained = 1'b0;
    rst_ni <= 1'b0;
    byte_ch.valid <= 1'b0;
    byte_ch.rx_byte <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Largest fields with stray letters and both byte extremes in front of the sentence.
    sentence_q.push_back(8'h00);
    sentence_q.push_back(8'hFF);
    add_text("WNA$GPRMC,235959,A,9999.9999,N,99999.9999,W,9999,*6F");
    add_line_end();
    // All zero, and a speed that begins with its decimal point.
    add_text("$GPRMC,000000,A,0000.0000,N,00000.0000,W,.999,*00");
    add_line_end();
    // Numbers that end early, a missing point and a field that starts with a sign.
    add_text("$GPRMC,C,A,4X12:3456,N,-124,56789,W,12.5,*11");
    add_line_end();
    // Degree field that starts with a letter, point at the wrong place, speed above 255.
    add_text("$GPRMC,A,N059.9,99,N,1239.12345,W,256.,*7E");
    add_line_end();
    fixes_planned = 4;
    send_sentence();
    wait_for_fixes();

    while (bytes_sent < ByteTarget || fixes_planned < FixTarget) begin
      send_burst = ($urandom_range(0, 3) == 0);
      build_random_sentence();
      send_sentence();
      random_sentences++;
      if (!mid_drained && random_sentences >= MidDrainAt) begin
        wait_for_fixes();
        mid_drained = 1'b1;
      end
    end

    wait_for_fixes();
    repeat (TailCycles) @(posedge clk_i);
    if (mismatches == 0 && fixes_pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
